// ===== src/l2c_pkg.sv =====
// ============================================================================
// l2c_pkg: shared definitions for the LBA to CHS converter
// Field widths, register indexes, reset geometry and the head divide step.
// ============================================================================
`default_nettype none

package l2c_pkg;

    // Field widths
    localparam int ADDR_FIELD_W = 24;
    localparam int CYL_W        = 24;
    localparam int SPT_W        = 6;
    localparam int HEADS_W      = 8;
    localparam int PER_CYL_W    = SPT_W + HEADS_W;

    // Stream and config port widths
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;

    // Parameter default
    localparam int ADDRESS_WIDTH_DEF = 24;

    // Quotient bits resolved per pipeline stage
    localparam int STEPS_PER_STAGE = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS = 8'd1;

    // Reset geometry
    localparam logic [SPT_W-1:0]     SPT_RESET     = 6'd18;
    localparam logic [HEADS_W-1:0]   HEADS_RESET   = 8'd2;
    localparam logic [PER_CYL_W-1:0] PER_CYL_RESET = 14'd36;

    // Partial state of the head division: remainder and shifting quotient
    typedef struct packed {
        logic [SPT_W-1:0]   rem;
        logic [HEADS_W-1:0] aq;
    } hdiv_t;

    // Restoring division, STEPS_PER_STAGE quotient bits
    function automatic hdiv_t head_steps(input hdiv_t s, input logic [SPT_W-1:0] d);
        hdiv_t          r;
        logic [SPT_W:0] trial;
        r = s;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            trial = {r.rem, r.aq[HEADS_W-1]};
            r.aq  = {r.aq[HEADS_W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                trial   = trial - {1'b0, d};
                r.aq[0] = 1'b1;
            end
            r.rem = trial[SPT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lba_to_chs_converter.sv =====
// Pipeline: one register stage per four quotient bits.
// Throughput: one address per cycle; stages advance independently, so bubbles
//   collapse and a stalled result holds the pipe without loss.
// Reset: aresetn is synchronous, active low; empties the pipe and restores the
//   default geometry (18 sectors per track, 2 heads).
// ============================================================================
// lba_to_chs_converter: linear block address to cylinder/head/sector
// Pipelined restoring divider: address / (spt*heads), then rest / spt.
// ============================================================================
`default_nettype none

module lba_to_chs_converter #(
    parameter int ADDRESS_WIDTH = l2c_pkg::ADDRESS_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [l2c_pkg::IN_TDATA_W-1:0]    s_tdata,   // [23:0] block_address
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [l2c_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [23:0] cylinder_index,
                                                              // [31:24] head_index,
                                                              // [37:32] sector_number
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [l2c_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [l2c_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import l2c_pkg::*;

    // Datapath width: only the low ADDRESS_WIDTH bits of the field count
    localparam int DW  = (ADDRESS_WIDTH < ADDR_FIELD_W) ? ADDRESS_WIDTH : ADDR_FIELD_W;
    // Cylinder divider stages; dividend padded with leading zeros
    localparam int NS1 = (DW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DWP = NS1 * STEPS_PER_STAGE;
    // Head divider stages (quotient is below head count, so HEADS_W bits)
    localparam int NH  = HEADS_W / STEPS_PER_STAGE;
    localparam int NS  = NS1 + NH;

    typedef struct packed {
        logic [PER_CYL_W-1:0] rem;
        logic [DWP-1:0]       aq;
    } cdiv_t;

    // Restoring division, STEPS_PER_STAGE quotient bits of the cylinder
    function automatic cdiv_t cyl_steps(input cdiv_t s, input logic [PER_CYL_W-1:0] d);
        cdiv_t              r;
        logic [PER_CYL_W:0] trial;
        r = s;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            trial = {r.rem, r.aq[DWP-1]};
            r.aq  = {r.aq[DWP-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                trial   = trial - {1'b0, d};
                r.aq[0] = 1'b1;
            end
            r.rem = trial[PER_CYL_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Geometry registers. Zero reads as one, so both are kept in that
    // effective form; the sectors-per-cylinder product is refreshed in the
    // same edge as the write, so it is never stale.
    // ------------------------------------------------------------------
    logic [SPT_W-1:0]     spt_eff_reg,   spt_eff_next;
    logic [HEADS_W-1:0]   heads_eff_reg, heads_eff_next;
    logic [PER_CYL_W-1:0] per_cyl_reg,   per_cyl_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        spt_eff_next   = spt_eff_reg;
        heads_eff_next = heads_eff_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SPT: begin
                    spt_eff_next = (cfg_data[SPT_W-1:0] == '0) ? SPT_W'(1)
                                                                : cfg_data[SPT_W-1:0];
                end
                REG_HEADS: begin
                    heads_eff_next = (cfg_data[HEADS_W-1:0] == '0) ? HEADS_W'(1)
                                                                    : cfg_data[HEADS_W-1:0];
                end
                default: ;  // unknown index: write dropped
            endcase
        end
        per_cyl_next = PER_CYL_W'(spt_eff_next) * PER_CYL_W'(heads_eff_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_eff_reg   <= SPT_RESET;
            heads_eff_reg <= HEADS_RESET;
            per_cyl_reg   <= PER_CYL_RESET;
        end else begin
            spt_eff_reg   <= spt_eff_next;
            heads_eff_reg <= heads_eff_next;
            per_cyl_reg   <= per_cyl_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_in;
    logic [NS:0]   rdy;

    assign vld_in = {vld_reg[NS-2:0], s_tvalid};

    always_comb begin
        rdy[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // Cylinder stages: address / sectors-per-cylinder
    // ------------------------------------------------------------------
    cdiv_t cdiv_reg  [NS1];
    cdiv_t cdiv_next [NS1];

    for (genvar k = 0; k < NS1; k++) begin : g_cyl
        if (k == 0) begin : g_first
            cdiv_t init;
            assign init.rem = '0;
            assign init.aq  = DWP'(s_tdata[DW-1:0]);
            assign cdiv_next[k] = cyl_steps(init, per_cyl_reg);
        end else begin : g_rest
            assign cdiv_next[k] = cyl_steps(cdiv_reg[k-1], per_cyl_reg);
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && vld_in[k]) begin
                cdiv_reg[k] <= cdiv_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Head stages: rest / sectors-per-track. rest >> HEADS_W is already
    // below spt, so it seeds the remainder and only HEADS_W steps remain.
    // ------------------------------------------------------------------
    hdiv_t            hdiv_reg  [NH];
    hdiv_t            hdiv_next [NH];
    logic [DW-1:0]    hcyl_reg  [NH];
    logic [DW-1:0]    hcyl_in   [NH];
    logic [SPT_W-1:0] sector_reg;

    for (genvar h = 0; h < NH; h++) begin : g_head
        if (h == 0) begin : g_first
            hdiv_t init;
            assign init.rem = cdiv_reg[NS1-1].rem[PER_CYL_W-1:HEADS_W];
            assign init.aq  = cdiv_reg[NS1-1].rem[HEADS_W-1:0];
            assign hdiv_next[h] = head_steps(init, spt_eff_reg);
            assign hcyl_in[h]   = cdiv_reg[NS1-1].aq[DW-1:0];
        end else begin : g_rest
            assign hdiv_next[h] = head_steps(hdiv_reg[h-1], spt_eff_reg);
            assign hcyl_in[h]   = hcyl_reg[h-1];
        end

        always_ff @(posedge aclk) begin
            if (rdy[NS1+h] && vld_in[NS1+h]) begin
                hdiv_reg[h] <= hdiv_next[h];
                hcyl_reg[h] <= hcyl_in[h];
            end
        end
    end

    // One-based sector from the final remainder
    always_ff @(posedge aclk) begin
        if (rdy[NS-1] && vld_in[NS-1]) begin
            sector_reg <= hdiv_next[NH-1].rem + SPT_W'(1);
        end
    end

    assign m_tdata = OUT_TDATA_W'({sector_reg, hdiv_reg[NH-1].aq, CYL_W'(hcyl_reg[NH-1])});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty or draining output stage lets the whole pipe take a transfer
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage free");

    // Sector stays within the track
    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sector_reg != '0 && sector_reg <= spt_eff_reg))
        else $error("sector number out of range");

    // Head stays below the head count
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hdiv_reg[NH-1].aq < heads_eff_reg))
        else $error("head index out of range");

endmodule

`default_nettype wire
